// ===== design/mmnb_pkg.sv =====
// shared types and constants for the min/max byte normalizer
// no dependencies; imported by every design file
package mmnb_pkg;

  localparam int unsigned SampleBitsDef = 32;
  localparam int unsigned CodeBits      = 8;
  localparam int unsigned QuotSteps     = 8;

  localparam logic [CodeBits-1:0] CodeNoData = 8'd0;
  localparam logic [CodeBits-1:0] CodeLow    = 8'd1;
  localparam logic [CodeBits-1:0] CodeHigh   = 8'd255;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_MEASURE = 2'd1,
    FUNC_CONVERT = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                done;
    logic [CodeBits-1:0] quot;
  } div_status_t;

endpackage

// ===== design/mmnb_div.sv =====
// restoring divider producing an 8-bit quotient, one bit per cycle
// depends on mmnb_pkg
module mmnb_div import mmnb_pkg::*; #(
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [SampleBits+7:0]   dividend_i,
  input  logic [SampleBits-1:0]   divisor_i,
  output div_status_t             status_o
);

  localparam int unsigned DivW = SampleBits + 8;

  logic [DivW-1:0]      rem_q, rem_d;
  logic [DivW-1:0]      dvs_q, dvs_d;
  logic [CodeBits-1:0]  quot_q, quot_d;
  logic [2:0]           cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 fits;

  assign fits = (rem_q >= dvs_q);

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      // divisor aligned to the top quotient bit
      dvs_d  = {1'b0, divisor_i, 7'b0};
      quot_d = '0;
      cnt_d  = 3'(QuotSteps - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dvs_q;
      end
      quot_d = {quot_q[CodeBits-2:0], fits};
      dvs_d  = dvs_q >> 1;
      cnt_d  = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign status_o.done = done_q;
  assign status_o.quot = quot_q;

endmodule

// ===== design/minmax_normalize_to_byte_core.sv =====
// convert item: accept, then PREP, CHECK, the divider loop in DIV, DONE and the result register
// early-out: no-data goes straight to DONE; empty or flat range and saturation end in CHECK
// clear and measure requests complete at accept; the next request can follow at once
// one request in flight: a convert stalls new requests until its code is loaded for output
// a stalled result register holds the sequencer in its last state until it drains
// async active-low reset: extremes return to empty range, no result pending
module minmax_normalize_to_byte_core import mmnb_pkg::*; #(
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   func_i,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic                         no_data_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [CodeBits-1:0]          code_o
);

  localparam int unsigned N = SampleBits;

  // empty range: lowest at most positive, highest at most negative
  localparam logic [N-1:0] MaxPos = {1'b0, {(N-1){1'b1}}};
  localparam logic [N-1:0] MinNeg = {1'b1, {(N-1){1'b0}}};

  state_e state_q, state_d;

  logic signed [N-1:0] lo_q, lo_d;
  logic signed [N-1:0] hi_q, hi_d;

  // held sample and the two differences against the extremes
  logic signed [N-1:0] v_q, v_d;
  logic signed [N:0]   d_q, d_d;
  logic signed [N:0]   r_q, r_d;

  logic [CodeBits-1:0] res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [CodeBits-1:0] code_q, code_d;

  logic                accept;
  logic                div_start;
  logic [N+7:0]        dividend;
  div_status_t         div_status;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // 254*d as (d << 8) - (d << 1), d known positive here
  assign dividend = {d_q[N-1:0], 8'b0} - {7'b0, d_q[N-1:0], 1'b0};

  mmnb_div #(
    .SampleBits (SampleBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (r_q[N-1:0]),
    .status_o   (div_status)
  );

  // sequencer: next state, extremes and result path
  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    v_d         = v_q;
    d_d         = d_q;
    r_d         = r_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    code_d      = code_q;
    div_start   = 1'b0;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_e'(func_i))
            FUNC_CLEAR: begin
              lo_d = MaxPos;
              hi_d = MinNeg;
            end
            FUNC_MEASURE: begin
              // missing samples leave the extremes alone
              if (!no_data_i) begin
                if (sample_i < lo_q) begin
                  lo_d = sample_i;
                end
                if (sample_i > hi_q) begin
                  hi_d = sample_i;
                end
              end
            end
            FUNC_CONVERT: begin
              v_d = sample_i;
              if (no_data_i) begin
                res_d   = CodeNoData;
                state_d = ST_DONE;
              end else begin
                state_d = ST_PREP;
              end
            end
            default: begin
              // unused function code, request dropped
            end
          endcase
        end
      end

      ST_PREP: begin
        d_d     = {v_q[N-1], v_q} - {lo_q[N-1], lo_q};
        r_d     = {hi_q[N-1], hi_q} - {lo_q[N-1], lo_q};
        state_d = ST_CHECK;
      end

      ST_CHECK: begin
        if (r_q[N] || (r_q == '0)) begin
          // nothing measured or flat range
          res_d   = CodeLow;
          state_d = ST_DONE;
        end else if (d_q[N] || (d_q == '0)) begin
          // at or below the measured minimum
          res_d   = CodeLow;
          state_d = ST_DONE;
        end else if (d_q >= r_q) begin
          // at or above the measured maximum
          res_d   = CodeHigh;
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_status.done) begin
          res_d   = div_status.quot + CodeLow;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // load the result register once it is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          code_d      = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lo_q        <= MaxPos;
      hi_q        <= MinNeg;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    d_q    <= d_d;
    r_q    <= r_d;
    res_q  <= res_d;
    code_q <= code_d;
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = code_q;

endmodule

// ===== design/mmnb_checker.sv =====
// port-level checks for minmax_normalize_to_byte_core, bound into that module
// depends on mmnb_pkg and minmax_normalize_to_byte_core
module mmnb_checker import mmnb_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [1:0]                   func_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [CodeBits-1:0]          code_o
);

  logic req_accept;
  assign req_accept = in_valid_i && !in_stall_o;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its code
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(code_o))
    else $error("result code changed while stalled");

  // a convert request keeps the block busy afterwards
  a_convert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept && (func_i == FUNC_CONVERT) |=> in_stall_o)
    else $error("convert request did not occupy the block");

  // clear and measure finish at accept
  a_other_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept && (func_i != FUNC_CONVERT) |=> !in_stall_o)
    else $error("non-convert request stalled the next one");

  // a new result only comes out of a busy convert
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a convert in flight");

endmodule

bind minmax_normalize_to_byte_core mmnb_checker u_mmnb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .code_o      (code_o)
);

// ===== dv/tb_top.sv =====
// self-checking bench for minmax_normalize_to_byte_core: clear, measure and convert requests
// a code ledger tracks the running extremes and queues the expected byte code per convert
// depends on mmnb_pkg and the design files under design/
`timescale 1ns / 1ps

module tb_top import mmnb_pkg::*;;

  localparam int unsigned SampleBits = SampleBitsDef;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned PhaseItems = 500;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [CodeBits-1:0]          code_t;

  // tracks the extremes the block should hold and the codes it still owes
  class code_ledger;
    sample_t     run_low;
    sample_t     run_high;
    code_t       pending_codes[$];
    int unsigned mismatch_count;

    function new();
      clear_extremes();
      mismatch_count = 0;
    endfunction

    // empty range: lowest at the top, highest at the bottom
    function void clear_extremes();
      run_low  = {1'b0, {(SampleBits-1){1'b1}}};
      run_high = {1'b1, {(SampleBits-1){1'b0}}};
    endfunction

    function code_t stretch_code(sample_t v, logic nd);
      logic [SampleBits:0]   span_off;
      logic [SampleBits:0]   span_full;
      logic [SampleBits+8:0] scaled;
      if (nd) return CodeNoData;
      if (run_high <= run_low) return CodeLow;
      if (v <= run_low) return CodeLow;
      if (v >= run_high) return CodeHigh;
      // one extra bit keeps both differences exact and positive
      span_off  = {v[SampleBits-1], v} - {run_low[SampleBits-1], run_low};
      span_full = {run_high[SampleBits-1], run_high} - {run_low[SampleBits-1], run_low};
      scaled    = (span_off * 9'd254) / span_full;
      return code_t'(scaled[CodeBits-1:0] + 1'b1);
    endfunction

    function void note_request(func_e f, sample_t s, logic nd);
      case (f)
        FUNC_CLEAR: begin
          clear_extremes();
        end
        FUNC_MEASURE: begin
          if (!nd) begin
            if (s < run_low) run_low = s;
            if (s > run_high) run_high = s;
          end
        end
        FUNC_CONVERT: begin
          pending_codes.push_back(stretch_code(s, nd));
        end
        default: begin
        end
      endcase
    endfunction

    function void check_code(code_t got);
      code_t want;
      if (pending_codes.size() == 0) begin
        $error("code: none expected, actual %0d", got);
        mismatch_count++;
        return;
      end
      want = pending_codes.pop_front();
      if (got !== want) begin
        $error("code: expected %0d, actual %0d", want, got);
        mismatch_count++;
      end
    endfunction
  endclass

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  func_e   func_i = FUNC_CLEAR;
  sample_t sample_i = '0;
  logic    no_data_i = 1'b0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  code_t   code_o;

  code_ledger  ledger;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  minmax_normalize_to_byte_core #(
    .SampleBits(SampleBits)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .sample_i   (sample_i),
    .no_data_i  (no_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .code_o     (code_o)
  );

  always #6 clk_i = ~clk_i;

  // hard stop in case the block hangs or drops a code
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver backpressure, redrawn every cycle at the current phase rate
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // a code leaves the block on a rising edge with valid high and stall low
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) ledger.check_code(code_o);
  end

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_request(func_e f, sample_t s, logic nd);
    // optional idle cycles ahead of the request
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    sample_i   <= s;
    no_data_i  <= nd;
    // hold the payload steady until the block takes it
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    ledger.note_request(f, s, nd);
    if (f != FUNC_NONE) items_sent++;
    @(negedge clk_i);
  endtask

  // an optional clear, a handful of measures, then a burst of converts against that range
  task automatic run_stretch_pass();
    sample_t     base;
    int unsigned span;
    int unsigned n_meas;
    int unsigned n_conv;
    sample_t     pick;
    base = sample_t'($urandom);
    case ($urandom_range(0, 2))
      0:       span = $urandom_range(0, 3);
      1:       span = $urandom_range(4, 5000);
      default: span = $urandom;
    endcase
    // now and then skip the clear so extremes carry over between passes
    if ($urandom_range(0, 9) != 0) begin
      send_request(FUNC_CLEAR, sample_t'($urandom), 1'($urandom_range(0, 1)));
    end
    n_meas = $urandom_range(0, 8);
    for (int k = 0; k < n_meas; k++) begin
      send_request(FUNC_MEASURE, sample_t'(base + sample_t'($urandom_range(0, span))),
                   ($urandom_range(0, 9) == 0));
    end
    n_conv = $urandom_range(1, 16);
    for (int k = 0; k < n_conv; k++) begin
      case ($urandom_range(0, 9))
        0:       pick = sample_t'($urandom);
        1:       pick = ledger.run_low;
        2:       pick = ledger.run_high;
        3:       pick = sample_t'(base - sample_t'($urandom_range(1, 100)));
        4:       pick = sample_t'(base + sample_t'(span) + sample_t'($urandom_range(1, 100)));
        default: pick = sample_t'(base + sample_t'($urandom_range(0, span)));
      endcase
      send_request(FUNC_CONVERT, pick, ($urandom_range(0, 9) == 0));
    end
  endtask

  initial begin
    int unsigned phase_start;
    sample_t     s_min;
    sample_t     s_max;
    ledger = new();
    s_min  = {1'b1, {(SampleBits-1){1'b0}}};
    s_max  = {1'b0, {(SampleBits-1){1'b1}}};

    // reset held low from time zero, released on a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty range, no-data, unused func, flat range
    send_request(FUNC_CONVERT, 5, 1'b0);
    send_request(FUNC_CONVERT, 7, 1'b1);
    send_request(FUNC_NONE, 0, 1'b0);
    send_request(FUNC_MEASURE, 123, 1'b1);
    send_request(FUNC_CONVERT, 0, 1'b0);
    send_request(FUNC_MEASURE, 42, 1'b0);
    send_request(FUNC_CONVERT, 42, 1'b0);
    send_request(FUNC_CONVERT, 1000, 1'b0);
    // full-scale range: both extremes and a few inner points
    send_request(FUNC_MEASURE, s_min, 1'b0);
    send_request(FUNC_MEASURE, s_max, 1'b0);
    send_request(FUNC_CONVERT, s_min, 1'b0);
    send_request(FUNC_CONVERT, s_max, 1'b0);
    send_request(FUNC_CONVERT, 0, 1'b0);
    send_request(FUNC_CONVERT, -1, 1'b0);
    send_request(FUNC_CONVERT, s_max - 1, 1'b0);
    // small range with saturation on both sides
    send_request(FUNC_CLEAR, -1, 1'b1);
    send_request(FUNC_MEASURE, 100, 1'b0);
    send_request(FUNC_MEASURE, 200, 1'b0);
    send_request(FUNC_CONVERT, 50, 1'b0);
    send_request(FUNC_CONVERT, 300, 1'b0);
    send_request(FUNC_CONVERT, 150, 1'b0);
    send_request(FUNC_CONVERT, 199, 1'b0);
    send_request(FUNC_CONVERT, 101, 1'b0);
    send_request(FUNC_CONVERT, -1, 1'b1);
    send_request(FUNC_NONE, -1, 1'b1);

    // random passes under four idle/stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray request of any kind, unused func included
          send_request(func_e'(2'($urandom_range(0, 3))), sample_t'($urandom),
                       1'($urandom_range(0, 1)));
        end else begin
          run_stretch_pass();
        end
      end
    end
    in_valid_i <= 1'b0;

    // drain outstanding codes, then keep watching for stray codes before the verdict
    while (ledger.pending_codes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (ledger.mismatch_count == 0 && ledger.pending_codes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== minmax_normalize_to_byte_core.f =====
design/mmnb_pkg.sv
design/mmnb_div.sv
design/minmax_normalize_to_byte_core.sv
design/mmnb_checker.sv
dv/tb_top.sv
